// ===== rtl/vrp_pkg.sv =====
// Shared types, widths and constants of the vertex rotate and project core.
`timescale 1ns / 1ps

package vrp_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int IN_W            = 24;
    localparam int ANG_W           = 18;
    localparam int ZOFF_W          = 16;
    localparam int DIM_W           = 12;
    localparam int OUT_W           = 16;
    localparam int CFG_DATA_W      = 18;
    localparam int CFG_IDX_W       = 3;

    localparam int CAMERA_DIST     = 5000;
    localparam int FOCAL_SCALE     = 1000;

    // Internal widths, sized from the input and register ranges.
    localparam int PROD_W  = IN_W + ANG_W;        // coordinate times angle
    localparam int ROT_W   = PROD_W + 1;          // first rotation sums
    localparam int WIDE_W  = 62;                  // second rotation, F+32 fraction bits
    localparam int RMAG_W  = 46;                  // rounded magnitude, F+16 fraction bits
    localparam int NUM_W   = RMAG_W + 10;         // magnitude times the focal scale
    localparam int DEN_W   = 44;                  // camera depth
    localparam int QUOT_W  = 18;                  // quotient bits kept before clamping

    localparam int ROT_STAGES = 6;
    localparam int DIV_STAGES = QUOT_W + 2;
    localparam int LATENCY    = ROT_STAGES + DIV_STAGES + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS    = 3'd0,
        REG_SIN    = 3'd1,
        REG_ZOFF   = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [ANG_W-1:0]  cos_angle;
        logic signed [ANG_W-1:0]  sin_angle;
        logic signed [ZOFF_W-1:0] z_offset;
        logic [DIM_W-1:0]         screen_width;
        logic [DIM_W-1:0]         screen_height;
    } cfg_t;

    typedef struct packed {
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [DEN_W-1:0] den;
        logic             neg_x;
        logic             neg_y;
        logic             degen;
    } proj_t;

endpackage

// ===== rtl/vertex_rotate_project_core.sv =====
// Top level of the vertex rotate and project core.
`timescale 1ns / 1ps

// One vertex is taken in every clock cycle (busy stays low), and its screen
// position appears on done after six stages of rotation and depth arithmetic,
// twenty stages of the two parallel dividers (an input stage, one quotient bit
// per stage after it, and a rounding stage), and two stages of sign, offset and
// saturation. Results cannot be held off. Register writes are always taken at once;
// they can act on items in flight, so write them only while no item is in the pipe.

module vertex_rotate_project_core
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [vrp_pkg::IN_W-1:0]         x_in,
    input  logic signed [vrp_pkg::IN_W-1:0]         y_in,
    input  logic signed [vrp_pkg::IN_W-1:0]         z_in,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [vrp_pkg::CFG_DATA_W-1:0]          cfg_data,
    output logic                                    done,
    output logic signed [vrp_pkg::OUT_W-1:0]        screen_col,
    output logic signed [vrp_pkg::OUT_W-1:0]        screen_row,
    output logic                                    degenerate
);
    import vrp_pkg::*;

    localparam int PX_W  = QUOT_W + 2;
    localparam int SUM_W = PX_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

    cfg_t  cfg_reg;
    logic  rot_valid;
    proj_t proj;

    logic              dx_valid, dy_valid;
    logic [QUOT_W:0]   qx, qy;
    logic [1:0]        tag_x;
    logic [0:0]        tag_y;

    logic                    a_vld_reg;
    logic signed [PX_W-1:0]  px_reg, py_reg;
    logic                    a_deg_reg;

    logic                    done_reg;
    logic signed [OUT_W-1:0] col_reg, row_reg;
    logic                    deg_reg;

    logic signed [SUM_W-1:0] col_sum, row_sum;
    logic signed [OUT_W-1:0] col_next, row_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_angle     <= ANG_W'(65536);
            cfg_reg.sin_angle     <= '0;
            cfg_reg.z_offset      <= ZOFF_W'(1);
            cfg_reg.screen_width  <= DIM_W'(1880);
            cfg_reg.screen_height <= DIM_W'(500);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COS:    cfg_reg.cos_angle     <= cfg_data[ANG_W-1:0];
                REG_SIN:    cfg_reg.sin_angle     <= cfg_data[ANG_W-1:0];
                REG_ZOFF:   cfg_reg.z_offset      <= cfg_data[ZOFF_W-1:0];
                REG_WIDTH:  cfg_reg.screen_width  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: cfg_reg.screen_height <= cfg_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    vrp_rotate u_rotate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .x_in      (x_in),
        .y_in      (y_in),
        .z_in      (z_in),
        .cfg       (cfg_reg),
        .out_valid (rot_valid),
        .out_proj  (proj)
    );

    vrp_div
    #(
        .N_W   (NUM_W),
        .D_W   (DEN_W),
        .Q_W   (QUOT_W),
        .TAG_W (2)
    )
    u_div_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .num       (proj.num_x),
        .den       (proj.den),
        .in_tag    ({proj.degen, proj.neg_x}),
        .out_valid (dx_valid),
        .quot      (qx),
        .out_tag   (tag_x)
    );

    vrp_div
    #(
        .N_W   (NUM_W),
        .D_W   (DEN_W),
        .Q_W   (QUOT_W),
        .TAG_W (1)
    )
    u_div_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .num       (proj.num_y),
        .den       (proj.den),
        .in_tag    (proj.neg_y),
        .out_valid (dy_valid),
        .quot      (qy),
        .out_tag   (tag_y)
    );

    always_comb
    begin
        col_sum = SUM_W'(px_reg) + $signed(SUM_W'(cfg_reg.screen_width >> 1));
        row_sum = $signed(SUM_W'(cfg_reg.screen_height >> 1)) - SUM_W'(py_reg);

        if (col_sum > SAT_HI)
            col_next = OUT_W'(SAT_HI);
        else if (col_sum < SAT_LO)
            col_next = OUT_W'(SAT_LO);
        else
            col_next = OUT_W'(col_sum);

        if (row_sum > SAT_HI)
            row_next = OUT_W'(SAT_HI);
        else if (row_sum < SAT_LO)
            row_next = OUT_W'(SAT_LO);
        else
            row_next = OUT_W'(row_sum);

        if (a_deg_reg)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg <= dx_valid && dy_valid;
            done_reg  <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= tag_x[0] ? -$signed(PX_W'(qx)) : $signed(PX_W'(qx));
        py_reg    <= tag_y[0] ? -$signed(PX_W'(qy)) : $signed(PX_W'(qy));
        a_deg_reg <= tag_x[1];
        col_reg   <= col_next;
        row_reg   <= row_next;
        deg_reg   <= a_deg_reg;
    end

    assign done       = done_reg;
    assign screen_col = col_reg;
    assign screen_row = row_reg;
    assign degenerate = deg_reg;

endmodule

// ===== rtl/vrp_rotate.sv =====
// Rotation, depth shift and numerator scaling: six register stages.
`timescale 1ns / 1ps

module vrp_rotate
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [vrp_pkg::IN_W-1:0]     x_in,
    input  logic signed [vrp_pkg::IN_W-1:0]     y_in,
    input  logic signed [vrp_pkg::IN_W-1:0]     z_in,
    input  vrp_pkg::cfg_t                       cfg,
    output logic                                out_valid,
    output vrp_pkg::proj_t                      out_proj
);
    import vrp_pkg::*;

    localparam int SHIFT1 = COORD_FRAC_BITS + 16;
    localparam logic signed [DEN_W-1:0] ZCAM_BIAS = DEN_W'(CAMERA_DIST) <<< SHIFT1;

    logic [ROT_STAGES-1:0] vld_reg;

    // Stage 1
    logic signed [PROD_W-1:0] xc_reg, zs_reg, xs_reg, zc_reg, ys_reg, yc_reg;
    // Stage 2
    logic signed [ROT_W-1:0]  nx_reg, nz_reg;
    logic signed [PROD_W-1:0] ys2_reg, yc2_reg;
    // Stage 3
    logic signed [WIDE_W-1:0] m1_reg, m2_reg;
    logic signed [ROT_W-1:0]  nz3_reg;
    logic signed [PROD_W-1:0] ys3_reg, yc3_reg;
    // Stage 4
    logic signed [WIDE_W-1:0] vx_reg, vy_reg;
    logic signed [DEN_W-1:0]  zcam_reg;
    // Stage 5
    logic [RMAG_W-1:0]        rxm_reg, rym_reg;
    logic                     rxn_reg, ryn_reg;
    logic [DEN_W-1:0]         zm_reg;
    logic                     zn_reg, zz_reg;
    // Stage 6
    proj_t                    proj_reg;

    logic signed [WIDE_W-1:0] vx_next, vy_next;
    logic signed [DEN_W-1:0]  zcam_next;
    logic [WIDE_W-1:0]        vx_mag, vy_mag;
    logic [RMAG_W-1:0]        rxm_next, rym_next;
    logic [DEN_W-1:0]         zm_next;

    always_comb
    begin
        vx_next   = WIDE_W'(m1_reg) - (WIDE_W'(ys3_reg) <<< 16);
        vy_next   = WIDE_W'(m2_reg) + (WIDE_W'(yc3_reg) <<< 16);
        zcam_next = DEN_W'(nz3_reg) + (DEN_W'(cfg.z_offset) <<< SHIFT1) + ZCAM_BIAS;
    end

    // Half-away rounding works on magnitudes; the dividers want them anyway.
    always_comb
    begin
        vx_mag   = vx_reg[WIDE_W-1] ? WIDE_W'(-vx_reg) : WIDE_W'(vx_reg);
        vy_mag   = vy_reg[WIDE_W-1] ? WIDE_W'(-vy_reg) : WIDE_W'(vy_reg);
        rxm_next = RMAG_W'((vx_mag + WIDE_W'(32768)) >> 16);
        rym_next = RMAG_W'((vy_mag + WIDE_W'(32768)) >> 16);
        zm_next  = zcam_reg[DEN_W-1] ? DEN_W'(-zcam_reg) : DEN_W'(zcam_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        xc_reg   <= x_in * cfg.cos_angle;
        zs_reg   <= z_in * cfg.sin_angle;
        xs_reg   <= x_in * cfg.sin_angle;
        zc_reg   <= z_in * cfg.cos_angle;
        ys_reg   <= y_in * cfg.sin_angle;
        yc_reg   <= y_in * cfg.cos_angle;

        nx_reg   <= ROT_W'(xc_reg) - ROT_W'(zs_reg);
        nz_reg   <= ROT_W'(xs_reg) + ROT_W'(zc_reg);
        ys2_reg  <= ys_reg;
        yc2_reg  <= yc_reg;

        m1_reg   <= WIDE_W'(nx_reg) * WIDE_W'(cfg.cos_angle);
        m2_reg   <= WIDE_W'(nx_reg) * WIDE_W'(cfg.sin_angle);
        nz3_reg  <= nz_reg;
        ys3_reg  <= ys2_reg;
        yc3_reg  <= yc2_reg;

        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        zcam_reg <= zcam_next;

        rxm_reg  <= rxm_next;
        rym_reg  <= rym_next;
        rxn_reg  <= vx_reg[WIDE_W-1];
        ryn_reg  <= vy_reg[WIDE_W-1];
        zm_reg   <= zm_next;
        zn_reg   <= zcam_reg[DEN_W-1];
        zz_reg   <= (zcam_reg == '0);

        proj_reg.num_x <= NUM_W'(rxm_reg) * NUM_W'(FOCAL_SCALE);
        proj_reg.num_y <= NUM_W'(rym_reg) * NUM_W'(FOCAL_SCALE);
        proj_reg.den   <= zm_reg;
        proj_reg.neg_x <= rxn_reg ^ zn_reg;
        proj_reg.neg_y <= ryn_reg ^ zn_reg;
        proj_reg.degen <= zz_reg;
    end

    assign out_valid = vld_reg[ROT_STAGES-1];
    assign out_proj  = proj_reg;

endmodule

// ===== rtl/vrp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with clamp and rounding.
`timescale 1ns / 1ps

module vrp_div
#(
    parameter int N_W   = vrp_pkg::NUM_W,
    parameter int D_W   = vrp_pkg::DEN_W,
    parameter int Q_W   = vrp_pkg::QUOT_W,
    parameter int TAG_W = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [N_W-1:0]   num,
    input  logic [D_W-1:0]   den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [Q_W:0]     quot,
    output logic [TAG_W-1:0] out_tag
);
    import vrp_pkg::*;

    logic [Q_W:0]     vld_reg;
    logic [D_W-1:0]   rem_reg [0:Q_W];
    logic [Q_W-1:0]   low_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic [D_W-1:0]   den_reg [0:Q_W];
    logic             ovf_reg [0:Q_W];
    logic [TAG_W-1:0] tag_reg [0:Q_W];

    logic             out_vld_reg;
    logic [Q_W:0]     quot_reg;
    logic [TAG_W-1:0] out_tag_reg;
    logic             rnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[Q_W-1:0], in_valid};
            out_vld_reg <= vld_reg[Q_W];
        end
    end

    // A quotient of 2^Q_W or more saturates the screen position, so it is clamped.
    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= ((N_W+Q_W+D_W)'(num) >= ((N_W+Q_W+D_W)'(den) << Q_W));
        rem_reg[0] <= D_W'(num >> Q_W);
        low_reg[0] <= num[Q_W-1:0];
        q_reg[0]   <= '0;
        den_reg[0] <= den;
        tag_reg[0] <= in_tag;
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [D_W:0] trial;
        logic         take;

        always_comb
        begin
            trial = {rem_reg[k], low_reg[k][Q_W-1]};
            take  = (trial >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= take ? D_W'(trial - {1'b0, den_reg[k]}) : D_W'(trial);
            low_reg[k+1] <= low_reg[k] << 1;
            q_reg[k+1]   <= Q_W'({q_reg[k], take});
            den_reg[k+1] <= den_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            tag_reg[k+1] <= tag_reg[k];
        end
    end

    assign rnd = ({rem_reg[Q_W], 1'b0} >= {1'b0, den_reg[Q_W]});

    always_ff @(posedge clk)
    begin
        quot_reg    <= ovf_reg[Q_W] ? (Q_W+1)'(1) << Q_W
                                    : (Q_W+1)'(q_reg[Q_W]) + (Q_W+1)'(rnd);
        out_tag_reg <= tag_reg[Q_W];
    end

    assign out_valid = out_vld_reg;
    assign quot      = quot_reg;
    assign out_tag   = out_tag_reg;

endmodule

// ===== rtl/vrp_checker.sv =====
// Port-level checks of the core, bound to the top level.
`timescale 1ns / 1ps

module vrp_port_checks
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic                                 done,
    input logic signed [vrp_pkg::OUT_W-1:0]     screen_col,
    input logic signed [vrp_pkg::OUT_W-1:0]     screen_row,
    input logic                                 degenerate
);
    import vrp_pkg::*;

    // Every accepted item comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not complete after the pipeline latency");

    // No result appears without an item accepted that long before.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted item");

    // A degenerate result carries a zero position.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (screen_col == '0 && screen_row == '0))
        else $error("degenerate result with nonzero position");

    // Register writes are never held off.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write stalled");

endmodule

bind vertex_rotate_project_core vrp_port_checks u_vrp_port_checks (.*);

// ===== verif/vrp_checker.sv =====
// Checker that predicts and compares the projected screen positions of the core.
`timescale 1ns / 1ps

module vrp_checker
    import vrp_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [IN_W-1:0]        x_in,
    input  logic signed [IN_W-1:0]        y_in,
    input  logic signed [IN_W-1:0]        z_in,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          done,
    input  logic signed [OUT_W-1:0]       screen_col,
    input  logic signed [OUT_W-1:0]       screen_row,
    input  logic                          degenerate,
    output int                            fail_count,
    output int                            pending_count
);

    typedef struct packed {
        logic signed [OUT_W-1:0] col;
        logic signed [OUT_W-1:0] row;
        logic                    degen;
    } pixel_t;

    cfg_t   view;
    pixel_t pixel_queue[$];

    // Magnitudes stay far below 2^126, so 128-bit signed math is exact.
    function automatic logic signed [127:0] round_away_div(
        input logic signed [127:0] n, input logic signed [127:0] d);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] q;
        logic signed [127:0] r;
        begin
            a = (n < 0) ? -n : n;
            b = (d < 0) ? -d : d;
            q = a / b;
            r = a % b;
            if (r >= b - r)
                q = q + 1;
            return ((n < 0) != (d < 0)) ? -q : q;
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp16(input logic signed [127:0] v);
        begin
            if (v > 32767)
                return 16'sh7fff;
            if (v < -32768)
                return 16'sh8000;
            return v[OUT_W-1:0];
        end
    endfunction

    function automatic pixel_t project_vertex(
        input logic signed [IN_W-1:0] xv,
        input logic signed [IN_W-1:0] yv,
        input logic signed [IN_W-1:0] zv);
        logic signed [127:0] x, y, z, c, s, unit, nx, nz, rx, ry, zcam;
        logic signed [127:0] half_w, half_h;
        pixel_t p;
        begin
            x = xv;
            y = yv;
            z = zv;
            c = view.cos_angle;
            s = view.sin_angle;
            unit = 128'sd1 <<< (COORD_FRAC_BITS + 16);
            nx = x * c - z * s;
            nz = x * s + z * c;
            rx = round_away_div(nx * c - y * s * 65536, 65536);
            ry = round_away_div(nx * s + y * c * 65536, 65536);
            zcam = nz + view.z_offset * unit + CAMERA_DIST * unit;
            if (zcam == 0) begin
                p.col = '0;
                p.row = '0;
                p.degen = 1'b1;
            end
            else begin
                half_w = view.screen_width / 2;
                half_h = view.screen_height / 2;
                p.col = clamp16(round_away_div(rx * FOCAL_SCALE, zcam) + half_w);
                p.row = clamp16(half_h - round_away_div(ry * FOCAL_SCALE, zcam));
                p.degen = 1'b0;
            end
            return p;
        end
    endfunction

    assign pending_count = pixel_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n) begin
            view.cos_angle     <= 18'sd65536;
            view.sin_angle     <= '0;
            view.z_offset      <= 16'sd1;
            view.screen_width  <= 12'd1880;
            view.screen_height <= 12'd500;
            fail_count         <= 0;
            pixel_queue.delete();
        end
        else begin
            if (done) begin
                if (pixel_queue.size() == 0) begin
                    $error("unexpected result col=%0d row=%0d", screen_col, screen_row);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = pixel_queue.pop_front();
                    if (want.col !== screen_col || want.row !== screen_row
                        || want.degen !== degenerate) begin
                        if (want.col !== screen_col)
                            $error("screen_col expected %0d actual %0d", want.col, screen_col);
                        if (want.row !== screen_row)
                            $error("screen_row expected %0d actual %0d", want.row, screen_row);
                        if (want.degen !== degenerate)
                            $error("degenerate expected %0d actual %0d", want.degen,
                                   degenerate);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                pixel_queue = {pixel_queue, project_vertex(x_in, y_in, z_in)};
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_COS:    view.cos_angle     <= cfg_data;
                    REG_SIN:    view.sin_angle     <= cfg_data;
                    REG_ZOFF:   view.z_offset      <= cfg_data[ZOFF_W-1:0];
                    REG_WIDTH:  view.screen_width  <= cfg_data[DIM_W-1:0];
                    REG_HEIGHT: view.screen_height <= cfg_data[DIM_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the testbench: drives vertices and register writes and gives the verdict.
`timescale 1ns / 1ps

module testbench;
    import vrp_pkg::*;

    localparam int DRAIN_CYCLES = LATENCY + 8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [IN_W-1:0]  x_in;
    logic signed [IN_W-1:0]  y_in;
    logic signed [IN_W-1:0]  z_in;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    done;
    logic signed [OUT_W-1:0] screen_col;
    logic signed [OUT_W-1:0] screen_row;
    logic                    degenerate;
    int                      fail_count;
    int                      pending_count;
    int                      burst_left;

    vertex_rotate_project_core dut (.*);

    vrp_checker checker_inst (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sends one vertex; gaps fall between bursts of random length.
    task automatic send_vertex(input logic [IN_W-1:0] xv, input logic [IN_W-1:0] yv,
                               input logic [IN_W-1:0] zv);
        int gap;
        begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 30);
            end
            burst_left = burst_left - 1;
            start <= 1'b1;
            x_in  <= xv;
            y_in  <= yv;
            z_in  <= zv;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    task automatic drain_pipe();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_count != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // Leaves valid high so that writes can follow back to back; the caller drops it.
    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
    endtask

    // Realistic coordinates in half the picks, full-range and extreme values in the rest.
    function automatic logic [IN_W-1:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return IN_W'($urandom);
            1:       return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            default: return IN_W'($signed($urandom_range(0, 8000 * 256)) - 1000 * 256);
        endcase
    endfunction

    // Vertex whose camera depth is exactly zero under the given z_offset when the rotation
    // is the identity: z = -(5000 + z_offset).
    task automatic send_zero_depth(input int zoff);
        begin
            send_vertex(IN_W'($urandom), IN_W'($urandom), IN_W'((-(5000 + zoff)) * 256));
        end
    endtask

    logic [CFG_DATA_W-1:0] cos_set[6] = '{18'h10000, 18'h20000, 18'h0b505, 18'h00000,
                                          18'h1ffff, 18'h30000};
    logic [CFG_DATA_W-1:0] sin_set[6] = '{18'h00000, 18'h00000, 18'h0b505, 18'h10000,
                                          18'h20000, 18'h3ffff};
    logic [15:0]           zoff_set[6] = '{16'h0001, 16'h7fff, 16'h8000, 16'hec78,
                                           16'h0000, 16'hfc18};
    logic [11:0]           width_set[6] = '{12'd1880, 12'd4095, 12'd1, 12'd0, 12'd640,
                                            12'd4095};
    logic [11:0]           height_set[6] = '{12'd500, 12'd4095, 12'd1, 12'd0, 12'd480,
                                             12'd2};

    initial
    begin
        rst_n     = 1'b0;
        clk       = 1'b0;
        start     = 1'b0;
        x_in      = '0;
        y_in      = '0;
        z_in      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed vertices at reset settings, zero depth included.
        send_vertex('0, '0, '0);
        send_vertex(24'h7fffff, 24'h7fffff, 24'h7fffff);
        send_vertex(24'h800000, 24'h800000, 24'h800000);
        send_vertex(24'h7fffff, 24'h800000, 24'h000000);
        send_vertex(24'h800000, 24'h7fffff, 24'hffffff);
        send_vertex(IN_W'(256), IN_W'(-256), '0);
        send_vertex(IN_W'(128), IN_W'(-128), '0);
        send_vertex(24'h00ffff, 24'hff0000, IN_W'(-5000 * 256));
        send_zero_depth(1);
        send_zero_depth(1);
        send_vertex(24'h555555, 24'haaaaaa, 24'h555555);
        send_vertex(24'haaaaaa, 24'h555555, 24'haaaaaa);
        send_vertex(IN_W'(5 * 256), IN_W'(7 * 256), IN_W'(-5001 * 256 + 1));
        send_vertex(24'h000001, 24'hffffff, IN_W'(-5001 * 256 - 1));
        drain_pipe();

        for (int phase = 0; phase < 6; phase++) begin
            write_register(REG_COS, cos_set[phase]);
            write_register(REG_SIN, sin_set[phase]);
            write_register(REG_ZOFF, {2'b00, zoff_set[phase]});
            write_register(REG_WIDTH, {6'h00, width_set[phase]});
            write_register(REG_HEIGHT, {6'h00, height_set[phase]});
            // An index beyond the list must be ignored.
            cfg_valid <= 1'b1;
            cfg_index <= REG_UNUSED;
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            if (phase == 0 || phase == 4)
                send_zero_depth($signed(zoff_set[phase]));
            for (int i = 0; i < 90; i++)
                send_vertex(pick_coord(), pick_coord(), pick_coord());
            drain_pipe();
        end

        if (fail_count == 0)
            $display("vertex_rotate_project_core: match");
        else
            $display("vertex_rotate_project_core: mismatch");
        $finish;
    end

    initial
    begin
        #200000;
        $display("vertex_rotate_project_core: mismatch");
        $finish;
    end

endmodule
